@@ hw/rtl/tdpt_pkg.sv @@
// Shared types and constants of the trial-division prime test.
// Used by the front, queue, back and top-level files; depends on nothing.

package tdpt_pkg;

    // Width of the candidate field in the input stream.
    localparam int unsigned CAND_W = 32;

    // Width of the result byte in the output stream.
    localparam int unsigned OUT_W = 8;

    // Entries in the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned SMALLEST_PRIME = 2;
    localparam int unsigned FIRST_DIVISOR  = 3;
    localparam int unsigned DIVISOR_STEP   = 2;

    // How the front classified a candidate.
    typedef enum logic [1:0] {
        KIND_NOT_PRIME,
        KIND_PRIME,
        KIND_TEST
    } kind_t;

    localparam int unsigned KIND_W = 2;

    // Status of the back, seen by the queue and the top level.
    typedef struct packed {
        logic pop;
        logic busy;
        logic done;
    } back_status_t;

endpackage

@@ hw/rtl/tdpt_front.sv @@
// Front of the prime test: takes input items and classifies each candidate.
// Depends on tdpt_pkg; feeds tdpt_queue.

module tdpt_front #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [tdpt_pkg::CAND_W-1:0]           s_data,
    input  logic                                  queue_full,
    output logic                                  push,
    output logic [NUM_WIDTH+tdpt_pkg::KIND_W-1:0] entry
);
    import tdpt_pkg::*;

    logic [NUM_WIDTH-1:0] num;
    kind_t                kind;

    // Bits above the configured width are dropped, missing ones are zero.
    assign num = NUM_WIDTH'(s_data);

    always_comb
    begin
        if (num < NUM_WIDTH'(SMALLEST_PRIME))
        begin
            kind = KIND_NOT_PRIME;
        end
        else if (num == NUM_WIDTH'(SMALLEST_PRIME))
        begin
            kind = KIND_PRIME;
        end
        else if (!num[0])
        begin
            kind = KIND_NOT_PRIME;
        end
        else
        begin
            kind = KIND_TEST;
        end
    end

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;
    assign entry   = {kind, num};

endmodule

@@ hw/rtl/tdpt_queue.sv @@
// Short queue between the front and the back of the prime test.
// Depends on tdpt_pkg for its depth.

module tdpt_queue #(
    parameter int WIDTH = 34
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import tdpt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/tdpt_back.sv @@
// Back of the prime test: runs trial division on one queued candidate at a time
// with a bit-serial remainder unit, and holds the result in an output register.
// Depends on tdpt_pkg; fed by tdpt_queue.

module tdpt_back #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  logic [NUM_WIDTH+tdpt_pkg::KIND_W-1:0] q_data,
    output tdpt_pkg::back_status_t                status,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_prime
);
    import tdpt_pkg::*;

    // Divisor width covers the square root of the largest candidate plus a step.
    localparam int DW = NUM_WIDTH / 2 + 2;
    // The running square may pass the candidate by one step before the loop stops.
    localparam int SW = NUM_WIDTH + 2;
    localparam int CW = $clog2(NUM_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_prime_reg, out_prime_next;
    logic                 prime_reg, prime_next;
    logic [NUM_WIDTH-1:0] num_reg, num_next;
    logic [DW-1:0]        div_reg, div_next;
    logic [SW-1:0]        sq_reg, sq_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    kind_t                q_kind;
    logic [NUM_WIDTH-1:0] q_num;
    logic                 out_free;
    logic                 pop;
    logic [DW:0]          rem_shift;
    logic [DW:0]          rem_diff;
    logic [DW-1:0]        rem_trial;

    assign q_kind = kind_t'(q_data[NUM_WIDTH +: KIND_W]);
    assign q_num  = q_data[NUM_WIDTH-1:0];

    assign out_free = !out_valid_reg || out_ready;

    // One restoring-division step: bring down the next candidate bit.
    assign rem_shift = {rem_reg, num_reg[cnt_reg]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_trial = (rem_shift >= {1'b0, div_reg}) ? rem_diff[DW-1:0] : rem_shift[DW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_prime_next = out_prime_reg;
        prime_next     = prime_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        pop            = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (q_kind == KIND_TEST)
                    begin
                        num_next   = q_num;
                        div_next   = DW'(FIRST_DIVISOR);
                        sq_next    = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        prime_next = (q_kind == KIND_PRIME);
                        state_next = S_DONE;
                    end
                end
            end
            S_CHECK:
            begin
                // Once the divisor squared exceeds the candidate, no factor is left.
                if (sq_reg > SW'(num_reg))
                begin
                    prime_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = CW'(NUM_WIDTH - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_trial;
                if (cnt_reg == '0)
                begin
                    if (rem_trial == '0)
                    begin
                        prime_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        div_next   = div_reg + DW'(DIVISOR_STEP);
                        sq_next    = sq_reg + (SW'(div_reg) << 2) + SW'(4);
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_prime_next = prime_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prime_reg <= out_prime_next;
        prime_reg     <= prime_next;
        num_reg       <= num_next;
        div_reg       <= div_next;
        sq_reg        <= sq_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
    end

    assign status.pop  = pop;
    assign status.busy = (state_reg != S_IDLE);
    assign status.done = (state_reg == S_DONE) && out_free;

    assign out_valid = out_valid_reg;
    assign out_prime = out_prime_reg;

endmodule

@@ hw/rtl/trial_division_prime_test.sv @@
// Top level of the trial-division prime test.
// Depends on tdpt_pkg, tdpt_front, tdpt_queue and tdpt_back.
//
// Input stream s_axis: one candidate per item in tdata. Only its low NUM_WIDTH
// bits are tested. Output stream m_axis: one item per candidate, in order,
// with bit 0 of tdata set when the candidate is prime.
// Zero and one are reported not prime, two is prime, other even numbers not.
// The front classifies each candidate and places it in a two-entry queue, so
// new items are taken while the back is still working.
// With an idle back, the result for zero, one or an even candidate passes
// through the queue, the back's S_DONE state and the output register. An odd
// candidate n is also divided by each odd divisor d from three while
// d * d <= n. Each division runs in the bit-serial remainder unit, which
// brings down one candidate bit per cycle; one item is divided at a time.
// Reset empties the queue and the output register; a candidate in work is lost.
// When m_axis_tready is low, the finished result holds in the output register,
// the back waits with the next one, and the queue fills until s_axis_tready
// drops.

module trial_division_prime_test #(
    parameter int NUM_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [tdpt_pkg::CAND_W-1:0]        s_axis_tdata,   // [31:0] candidate
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [tdpt_pkg::OUT_W-1:0]         m_axis_tdata    // [0] is_prime, [7:1] zero
);
    import tdpt_pkg::*;

    localparam int ENTRY_W = NUM_WIDTH + KIND_W;

    logic               push;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] pop_entry;
    logic               q_full;
    logic               q_empty;
    back_status_t       back_st;
    logic               is_prime;

    tdpt_front #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_front (
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .queue_full (q_full),
        .push       (push),
        .entry      (push_entry)
    );

    tdpt_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (back_st.pop),
        .pop_data  (pop_entry),
        .empty     (q_empty)
    );

    tdpt_back #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_empty),
        .q_data    (pop_entry),
        .status    (back_st),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_prime (is_prime)
    );

    assign m_axis_tdata = {{(OUT_W-1){1'b0}}, is_prime};

    // The back never takes an entry from an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        back_st.pop |-> !q_empty)
        else $error("back popped an empty queue");

    // An idle back with a waiting entry starts on it in the next cycle.
    a_idle_starts: assert property (@(posedge clk) disable iff (!rst_n)
        !back_st.busy && !q_empty |=> back_st.busy)
        else $error("back stayed idle with a queued item");

    // A new result appears only after the back finished an item.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(back_st.done))
        else $error("result appeared without a finished item");

endmodule
